// ----- design/spu_pkg.sv -----
// Package: shared field widths, item types, controller states and command/status structs.
`timescale 1ns / 1ps
`default_nettype none
package spu_pkg;

    // Fixed field widths of the channels
    localparam int ELEM_COUNT_W = 5;
    localparam int SEED_W       = 32;
    localparam int POS_W        = 4;
    localparam int VAL_W        = 4;

    // Input item
    typedef struct packed {
        logic [ELEM_COUNT_W-1:0] elem_count;
        logic [SEED_W-1:0]       seed_word;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] elem_value;
        logic             last;
    } out_item_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_CHECK,
        ST_DIV_WAIT,
        ST_SWAP_RD,
        ST_WR_I,
        ST_WR_J,
        ST_STEP,
        ST_OUT_RD,
        ST_OUT_SHOW
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture count and seed, clear counters
        logic fill_wr;    // write identity entry at fill index
        logic k_clr;      // clear fill/output index
        logic div_start;  // start remainder/radix division
        logic swap_rd;    // read both swap entries
        logic wr_i;       // write entry from position j into position i
        logic wr_j;       // write entry from position i into position j
        logic step_adv;   // take quotient, advance step index
        logic out_rd;     // read next output entry
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic n_zero;
        logic fill_last;
        logic more_steps;
        logic div_busy;
        logic digit_zero;
        logic out_last;
    } status_t;

endpackage
`default_nettype wire

// ----- design/spu_if.sv -----
// Interfaces: valid/ready channels for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface spu_in_if;
    logic              valid;
    logic              ready;
    spu_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface spu_out_if;
    logic               valid;
    logic               ready;
    spu_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

// ----- design/spu_div.sv -----
// Divider: restoring, one quotient bit per cycle, seed word by a narrow radix.
`timescale 1ns / 1ps
`default_nettype none
module spu_div #(
    parameter int DIV_W = 5
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [spu_pkg::SEED_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]           divisor,
    output logic                            busy,
    output logic [spu_pkg::SEED_W-1:0]      quot,
    output logic [DIV_W-1:0]                rmd
);

    localparam int CNT_BITS = $clog2(spu_pkg::SEED_W);

    logic                       busy_reg, busy_next;
    logic [CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic [spu_pkg::SEED_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]           rmd_reg, rmd_next;
    logic [DIV_W-1:0]           dvs_reg, dvs_next;
    logic [DIV_W:0]             trial;
    logic [DIV_W:0]             diff;
    logic                       fits;

    // Shift one dividend bit into the partial remainder and try the subtract
    always_comb
    begin
        trial = {rmd_reg, quo_reg[spu_pkg::SEED_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Next state of the iteration
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rmd_next  = rmd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rmd_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[spu_pkg::SEED_W-2:0], fits};
            rmd_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(spu_pkg::SEED_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rmd_reg <= rmd_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign quot = quo_reg;
    assign rmd  = rmd_reg;

endmodule
`default_nettype wire

// ----- design/spu_dpath.sv -----
// Datapath: count and seed registers, step and index counters, permutation memory, divider.
`timescale 1ns / 1ps
`default_nettype none
module spu_dpath #(
    parameter int MAX_ELEMS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire spu_pkg::cmd_t                    cmd,
    output spu_pkg::status_t                      status,
    input  wire logic [spu_pkg::ELEM_COUNT_W-1:0] elem_count,
    input  wire logic [spu_pkg::SEED_W-1:0]       seed_word,
    output logic [spu_pkg::POS_W-1:0]             position,
    output logic [spu_pkg::VAL_W-1:0]             elem_value,
    output logic                                  last
);

    localparam int CNT_W = $clog2(MAX_ELEMS + 1);
    localparam int IDX_W = $clog2(MAX_ELEMS);
    localparam int CMP_W = (CNT_W > spu_pkg::ELEM_COUNT_W) ? CNT_W : spu_pkg::ELEM_COUNT_W;

    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [spu_pkg::SEED_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]           pos_reg;
    logic                       last_reg;
    logic [IDX_W-1:0]           rd_a_reg;
    logic [IDX_W-1:0]           rd_b_reg;
    logic [IDX_W-1:0]           perm_mem [MAX_ELEMS];

    logic [CMP_W-1:0]           cnt_ext;
    logic [CNT_W-1:0]           n_in;
    logic [CNT_W-1:0]           radix;
    logic [CNT_W-1:0]           j_full;
    logic [IDX_W-1:0]           i_idx;
    logic [IDX_W-1:0]           j_idx;
    logic [IDX_W-1:0]           k_idx;
    logic                       mem_we;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           wr_data;
    logic [IDX_W-1:0]           rd_addr;
    logic                       div_busy;
    logic [spu_pkg::SEED_W-1:0] div_quot;
    logic [CNT_W-1:0]           div_rmd;

    // Saturate the count to the store depth
    always_comb
    begin
        cnt_ext = CMP_W'(elem_count);
        if (cnt_ext > CMP_W'(MAX_ELEMS))
        begin
            n_in = CNT_W'(MAX_ELEMS);
        end
        else
        begin
            n_in = CNT_W'(cnt_ext);
        end
    end

    // Radix and swap partner of the current step
    assign radix  = n_reg - i_reg;
    assign j_full = i_reg + div_rmd;
    assign i_idx  = i_reg[IDX_W-1:0];
    assign j_idx  = j_full[IDX_W-1:0];
    assign k_idx  = k_reg[IDX_W-1:0];

    spu_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rem_reg),
        .divisor  (radix),
        .busy     (div_busy),
        .quot     (div_quot),
        .rmd      (div_rmd)
    );

    // Advance counters and the seed remainder
    always_comb
    begin
        n_next   = n_reg;
        i_next   = i_reg;
        k_next   = k_reg;
        rem_next = rem_reg;
        if (cmd.load)
        begin
            n_next   = n_in;
            i_next   = '0;
            k_next   = '0;
            rem_next = seed_word;
        end
        if (cmd.fill_wr || cmd.out_rd)
        begin
            k_next = k_reg + CNT_W'(1);
        end
        if (cmd.k_clr)
        begin
            k_next = '0;
        end
        if (cmd.step_adv)
        begin
            i_next   = i_reg + CNT_W'(1);
            rem_next = div_quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            i_reg   <= '0;
            k_reg   <= '0;
            rem_reg <= '0;
        end
        else
        begin
            n_reg   <= n_next;
            i_reg   <= i_next;
            k_reg   <= k_next;
            rem_reg <= rem_next;
        end
    end

    // Select memory write port: identity fill or one half of a swap
    always_comb
    begin
        mem_we  = cmd.fill_wr || cmd.wr_i || cmd.wr_j;
        wr_addr = k_idx;
        wr_data = k_idx;
        if (cmd.wr_i)
        begin
            wr_addr = i_idx;
            wr_data = rd_b_reg;
        end
        else if (cmd.wr_j)
        begin
            wr_addr = j_idx;
            wr_data = rd_a_reg;
        end
    end

    assign rd_addr = cmd.out_rd ? k_idx : i_idx;

    // Permutation memory with registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[wr_addr] <= wr_data;
        end
        if (cmd.swap_rd || cmd.out_rd)
        begin
            rd_a_reg <= perm_mem[rd_addr];
        end
        if (cmd.swap_rd)
        begin
            rd_b_reg <= perm_mem[j_idx];
        end
    end

    // Hold position and last marker of the item being shown
    always_ff @(posedge clk)
    begin
        if (cmd.out_rd)
        begin
            pos_reg  <= k_reg;
            last_reg <= (CNT_W'(k_reg + CNT_W'(1)) == n_reg);
        end
    end

    assign position   = spu_pkg::POS_W'(pos_reg);
    assign elem_value = spu_pkg::VAL_W'(rd_a_reg);
    assign last       = last_reg;

    // Report status
    always_comb
    begin
        status.n_zero     = (n_reg == '0);
        status.fill_last  = (CNT_W'(k_reg + CNT_W'(1)) == n_reg);
        status.more_steps = (CNT_W'(i_reg + CNT_W'(1)) < n_reg);
        status.div_busy   = div_busy;
        status.digit_zero = (div_rmd == '0);
        status.out_last   = last_reg;
    end

endmodule
`default_nettype wire

// ----- design/spu_ctrl.sv -----
// Controller: state machine that sequences fill, divide/swap steps and output beats.
`timescale 1ns / 1ps
`default_nettype none
module spu_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output spu_pkg::cmd_t         cmd,
    input  wire spu_pkg::status_t status
);

    spu_pkg::state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            spu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = spu_pkg::ST_FILL;
                end
            end
            spu_pkg::ST_FILL:
            begin
                if (status.n_zero)
                begin
                    state_next = spu_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.fill_wr = 1'b1;
                    if (status.fill_last)
                    begin
                        state_next = spu_pkg::ST_CHECK;
                    end
                end
            end
            spu_pkg::ST_CHECK:
            begin
                cmd.k_clr = 1'b1;
                if (status.more_steps)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = spu_pkg::ST_DIV_WAIT;
                end
                else
                begin
                    state_next = spu_pkg::ST_OUT_RD;
                end
            end
            spu_pkg::ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = status.digit_zero ? spu_pkg::ST_STEP : spu_pkg::ST_SWAP_RD;
                end
            end
            spu_pkg::ST_SWAP_RD:
            begin
                cmd.swap_rd = 1'b1;
                state_next  = spu_pkg::ST_WR_I;
            end
            spu_pkg::ST_WR_I:
            begin
                cmd.wr_i   = 1'b1;
                state_next = spu_pkg::ST_WR_J;
            end
            spu_pkg::ST_WR_J:
            begin
                cmd.wr_j   = 1'b1;
                state_next = spu_pkg::ST_STEP;
            end
            spu_pkg::ST_STEP:
            begin
                cmd.step_adv = 1'b1;
                state_next   = spu_pkg::ST_CHECK;
            end
            spu_pkg::ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = spu_pkg::ST_OUT_SHOW;
            end
            spu_pkg::ST_OUT_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = status.out_last ? spu_pkg::ST_IDLE : spu_pkg::ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = spu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/seed_permutation_unrank_core.sv -----
// Top level: permutation unranking from a seed, one count/seed item in, one result item out
//   per element, the count saturated to MAX_ELEMS. Sequence: accept, identity fill, n-1 steps,
//   each a bit-serial divide of the seed remainder by the radix and a swap if the digit is
//   nonzero; then a check, and a read and show per result item. Items go one at a time.
// A count of zero gives no result item.
// Reset: rst_n asynchronous, active low, returns the controller to idle; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module seed_permutation_unrank_core #(
    parameter int MAX_ELEMS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spu_in_if.sink     request,
    spu_out_if.source  result
);

    spu_pkg::cmd_t    cmd;
    spu_pkg::status_t status;

    spu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    spu_dpath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .elem_count (request.item.elem_count),
        .seed_word  (request.item.seed_word),
        .position   (result.item.position),
        .elem_value (result.item.elem_value),
        .last       (result.item.last)
    );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for seed_permutation_unrank_core: directed table plus random items, checked per item.
`timescale 1ns / 1ps
module testbench;

    localparam int MAX_ELEMS      = 16;
    localparam int RANDOM_ITEMS   = 87;
    localparam int DRAIN_CYCLES   = 650;
    localparam int WATCHDOG_LIMIT = 6000;

    // How the expected result items of a table row are formed
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_IDENTITY,
        ROW_EMPTY
    } row_kind_t;

    typedef struct packed {
        logic [spu_pkg::ELEM_COUNT_W-1:0] elem_count;
        logic [spu_pkg::SEED_W-1:0]       seed_word;
        row_kind_t                        kind;
        logic [4:0]                       identity_len;
    } stim_row_t;

    // Directed rows; identity and empty results are typed in, the rest go to the predictor
    localparam int DIRECTED_ROWS = 23;
    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{5'd1,  32'h0000_0000, ROW_IDENTITY, 5'd1},
        '{5'd1,  32'hFFFF_FFFF, ROW_IDENTITY, 5'd1},
        '{5'd16, 32'h0000_0000, ROW_IDENTITY, 5'd16},
        '{5'd16, 32'hFFFF_FFFF, ROW_PREDICT,  5'd0},
        '{5'd2,  32'h0000_0000, ROW_IDENTITY, 5'd2},
        '{5'd2,  32'h0000_0001, ROW_PREDICT,  5'd0},
        '{5'd2,  32'hFFFF_FFFF, ROW_PREDICT,  5'd0},
        '{5'd0,  32'h1234_5678, ROW_EMPTY,    5'd0},
        '{5'd0,  32'hFFFF_FFFF, ROW_EMPTY,    5'd0},
        '{5'd17, 32'h0000_0000, ROW_IDENTITY, 5'd16},
        '{5'd31, 32'h0000_0000, ROW_IDENTITY, 5'd16},
        '{5'd31, 32'hA5A5_A5A5, ROW_PREDICT,  5'd0},
        '{5'd20, 32'h8000_0000, ROW_PREDICT,  5'd0},
        '{5'd16, 32'h8000_0000, ROW_PREDICT,  5'd0},
        '{5'd16, 32'h0000_0001, ROW_PREDICT,  5'd0},
        '{5'd16, 32'h0000_000F, ROW_PREDICT,  5'd0},
        '{5'd15, 32'h1234_5678, ROW_PREDICT,  5'd0},
        '{5'd8,  32'd40319,     ROW_PREDICT,  5'd0},
        '{5'd3,  32'd5,         ROW_PREDICT,  5'd0},
        '{5'd13, 32'hDEAD_BEEF, ROW_PREDICT,  5'd0},
        '{5'd16, 32'h5555_5555, ROW_PREDICT,  5'd0},
        '{5'd16, 32'hAAAA_AAAA, ROW_PREDICT,  5'd0},
        '{5'd9,  32'h7FFF_FFFF, ROW_PREDICT,  5'd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              req_valid = 1'b0;
    spu_pkg::in_item_t req_item  = '0;
    logic              res_ready = 1'b0;

    spu_in_if  request_if ();
    spu_out_if result_if ();

    assign request_if.valid = req_valid;
    assign request_if.item  = req_item;
    assign result_if.ready  = res_ready;

    seed_permutation_unrank_core #(
        .MAX_ELEMS(MAX_ELEMS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_if),
        .result (result_if)
    );

    stim_row_t          stim_rows [$];
    spu_pkg::out_item_t expected_beats [$];
    int                 mismatch_count = 0;
    int                 send_idx       = 0;

    always #6 clk = ~clk;

    // Unrank the seed into a permutation and queue one result item per position
    task automatic predict_perm(input logic [spu_pkg::ELEM_COUNT_W-1:0] count,
                                input logic [spu_pkg::SEED_W-1:0] seed);
        logic [3:0]         order [MAX_ELEMS];
        logic [31:0]        rem;
        logic [31:0]        radix;
        logic [31:0]        digit;
        logic [3:0]         swap_val;
        spu_pkg::out_item_t beat;
        int                 n;
        int                 k;
        rem = seed;
        n   = count;
        if (n > MAX_ELEMS)
        begin
            n = MAX_ELEMS;
        end
        if (n == 0)
        begin
            return;
        end
        for (k = 0; k < n; k++)
        begin
            order[k] = k[3:0];
        end
        for (k = 0; k + 1 < n; k++)
        begin
            radix = n - k;
            digit = rem % radix;
            if (digit != 0)
            begin
                swap_val              = order[k];
                order[k]              = order[k + digit];
                order[k + digit]      = swap_val;
            end
            rem = rem / radix;
        end
        for (k = 0; k < n; k++)
        begin
            beat.position   = k[3:0];
            beat.elem_value = order[k];
            beat.last       = (k + 1 == n);
            expected_beats.push_back(beat);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Sender: bursts of items separated by random gaps; hold valid until taken
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        logic               took;
        stim_row_t          row;
        spu_pkg::out_item_t beat;
        int                 k;
        took = req_valid && request_if.ready;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (took)
            begin
                row = stim_rows[send_idx];
                case (row.kind)
                    ROW_PREDICT:
                    begin
                        predict_perm(row.elem_count, row.seed_word);
                    end
                    ROW_IDENTITY:
                    begin
                        for (k = 0; k < row.identity_len; k++)
                        begin
                            beat.position   = k[3:0];
                            beat.elem_value = k[3:0];
                            beat.last       = (k + 1 == row.identity_len);
                            expected_beats.push_back(beat);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                send_idx++;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
            end
            if (req_valid && !took)
            begin
                // hold the offered item
            end
            else if (send_idx < stim_rows.size() && gap_left == 0 && burst_left > 0)
            begin
                req_valid           <= 1'b1;
                req_item.elem_count <= stim_rows[send_idx].elem_count;
                req_item.seed_word  <= stim_rows[send_idx].seed_word;
            end
            else
            begin
                req_valid <= 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 6);
                    case ($urandom_range(0, 7))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(40, 800);
                        default: gap_left = $urandom_range(1, 40);
                    endcase
                end
            end
        end
    end

    // Receiver: switch between stall patterns every so often
    int stall_mode = 0;
    int mode_left  = 0;
    int low_left   = 0;
    int phase      = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= 1'($urandom_range(0, 1));
                2:
                begin
                    phase++;
                    res_ready <= (phase % 3 == 0);
                end
                default:
                begin
                    if (low_left > 0)
                    begin
                        low_left--;
                        res_ready <= 1'b0;
                    end
                    else
                    begin
                        res_ready <= 1'b1;
                        low_left = $urandom_range(0, 25);
                    end
                end
            endcase
        end
    end

    // Checker: compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        spu_pkg::out_item_t got;
        spu_pkg::out_item_t want;
        if (rst_n && result_if.valid && res_ready)
        begin
            got = result_if.item;
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item position %0d value %0d last %0d",
                                          got.position, got.elem_value, got.last));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.position !== want.position)
                begin
                    report_mismatch($sformatf("position got %0d expected %0d",
                                              got.position, want.position));
                end
                if (got.elem_value !== want.elem_value)
                begin
                    report_mismatch($sformatf("elem_value at %0d got %0d expected %0d",
                                              want.position, got.elem_value, want.elem_value));
                end
                if (got.last !== want.last)
                begin
                    report_mismatch($sformatf("last at %0d got %0d expected %0d",
                                              want.position, got.last, want.last));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && request_if.ready) || (result_if.valid && res_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Build stimulus, release reset, wait for the drain, then report
    initial
    begin
        stim_row_t row;
        int        k;
        int        pick;
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            stim_rows.push_back(directed_rows[k]);
        end
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            row.kind         = ROW_PREDICT;
            row.identity_len = '0;
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // noise: zero count or a count above the maximum
                row.elem_count = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
            end
            else if (pick < 4)
            begin
                row.elem_count = 5'($urandom_range(1, 4));
            end
            else
            begin
                row.elem_count = 5'($urandom_range(1, 16));
            end
            case ($urandom_range(0, 5))
                0:       row.seed_word = $urandom_range(0, 255);
                1:       row.seed_word = 32'hFFFF_FFFF ^ $urandom_range(0, 255);
                default: row.seed_word = $urandom;
            endcase
            stim_rows.push_back(row);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (send_idx < stim_rows.size() || req_valid)
        begin
            @(posedge clk);
        end
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_beats.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
